### src/json_string_unescape_defines.svh
// Assertion macros used by the JSON string unescaper top level.
`ifndef JSON_STRING_UNESCAPE_DEFINES_SVH
`define JSON_STRING_UNESCAPE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check on every rising edge outside reset.
`define JSU_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("jsu assertion failed");

// Check on every rising edge, reset included.
`define JSU_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("jsu assertion failed");

`else

`define JSU_ASSERT(label, prop)
`define JSU_ASSERT_ALWAYS(label, prop)

`endif

`endif

### src/jsu_pkg.sv
// Types, character codes and helpers for the JSON string unescaper.
package jsu_pkg;

  localparam int unsigned MaxLen = 32'd65535;
  // Counters are 16 bits wide; they stop at the smaller of MaxLen and 65535.
  localparam logic [15:0] LenCap = (MaxLen < 32'd65535) ? 16'(MaxLen) : 16'hFFFF;

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_HEX
  } mode_t;

  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerF    = 8'h66;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChDigit9    = 8'h39;
  localparam logic [7:0] ChUpperF    = 8'h46;

  localparam logic [7:0] CodeBackspace = 8'h08;
  localparam logic [7:0] CodeFormFeed  = 8'h0C;
  localparam logic [7:0] CodeNewline   = 8'h0A;
  localparam logic [7:0] CodeReturn    = 8'h0D;
  localparam logic [7:0] CodeTab       = 8'h09;

  // Offsets that map a hex digit character onto its value.
  localparam logic [7:0] OffsDigit = 8'h30;
  localparam logic [7:0] OffsUpper = 8'h37;
  localparam logic [7:0] OffsLower = 8'h57;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  hex_count;
    logic [3:0]  high_nibble;
    logic [15:0] byte_position;
    logic [15:0] out_count;
    logic        error_seen;
    logic [15:0] error_position;
  } state_t;

  localparam state_t StateReset = '{
    mode:           MODE_NORMAL,
    hex_count:      2'd0,
    high_nibble:    4'd0,
    byte_position:  16'd0,
    out_count:      16'd0,
    error_seen:     1'b0,
    error_position: 16'd0
  };

  typedef struct packed {
    logic        valid;
    logic        has_byte;
    logic [7:0]  out_byte;
    logic        done;
    logic        error_flag;
    logic [15:0] error_offset;
    logic [15:0] decoded_length;
  } result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v >= LenCap) ? LenCap : v + 16'd1;
  endfunction

  // No check for a valid hex digit: every byte maps onto some nibble.
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    if (c <= ChDigit9) begin
      d = c - OffsDigit;
    end else if (c <= ChUpperF) begin
      d = c - OffsUpper;
    end else begin
      d = c - OffsLower;
    end
    return d[3:0];
  endfunction

endpackage

### src/jsu_decode.sv
// Combinational escape decoder: state and one raw byte in, next state and result out.
module jsu_decode
  import jsu_pkg::*;
(
  input  state_t      cur,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output state_t      nxt,
  output result_t     res
);

  logic       emit;
  logic [7:0] val;

  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    val  = 8'd0;
    if (!cur.error_seen) begin
      case (cur.mode)
        MODE_NORMAL: begin
          if (in_byte == ChBackslash) begin
            if (in_last) begin
              nxt.error_seen     = 1'b1;
              nxt.error_position = sat_inc(cur.byte_position);
            end else begin
              nxt.mode = MODE_ESCAPE;
            end
          end else begin
            emit = 1'b1;
            val  = in_byte;
          end
        end
        MODE_ESCAPE: begin
          nxt.mode = MODE_NORMAL;
          case (in_byte)
            ChQuote, ChBackslash, ChSlash: begin
              emit = 1'b1;
              val  = in_byte;
            end
            ChLowerB: begin emit = 1'b1; val = CodeBackspace; end
            ChLowerF: begin emit = 1'b1; val = CodeFormFeed;  end
            ChLowerN: begin emit = 1'b1; val = CodeNewline;   end
            ChLowerR: begin emit = 1'b1; val = CodeReturn;    end
            ChLowerT: begin emit = 1'b1; val = CodeTab;       end
            ChLowerU: begin
              if (in_last) begin
                nxt.error_seen     = 1'b1;
                nxt.error_position = cur.byte_position;
              end else begin
                nxt.mode      = MODE_HEX;
                nxt.hex_count = 2'd0;
              end
            end
            default: begin
              nxt.error_seen     = 1'b1;
              nxt.error_position = cur.byte_position;
            end
          endcase
        end
        MODE_HEX: begin
          if (cur.hex_count == 2'd3) begin
            emit          = 1'b1;
            val           = {cur.high_nibble, nibble_of(in_byte)};
            nxt.mode      = MODE_NORMAL;
            nxt.hex_count = 2'd0;
          end else if (in_last) begin
            nxt.error_seen     = 1'b1;
            nxt.error_position = cur.byte_position;
          end else begin
            if (cur.hex_count == 2'd2) begin
              nxt.high_nibble = nibble_of(in_byte);
            end
            nxt.hex_count = cur.hex_count + 2'd1;
          end
        end
        default: begin
          nxt = cur;
        end
      endcase
    end
    if (emit) begin
      nxt.out_count = sat_inc(cur.out_count);
    end
    nxt.byte_position = sat_inc(cur.byte_position);
  end

  always_comb begin
    res.valid          = emit | in_last;
    res.has_byte       = emit;
    res.out_byte       = val;
    res.done           = in_last;
    res.error_flag     = nxt.error_seen;
    res.error_offset   = nxt.error_seen ? nxt.error_position : 16'd0;
    res.decoded_length = nxt.out_count;
  end

endmodule

### src/json_string_unescape.sv
// Top level of the JSON string unescaper: input register, decode state and result register.
// The block takes the characters between the quotes of a JSON string, one per
// transaction, with in_last set on the final character, and hands out the
// unescaped bytes. A backslash opens an escape; quote, backslash and slash pass
// as themselves, b f n r t become control codes, and \u takes four hex digits of
// which the last two form the byte. A malformed escape, a trailing backslash or
// a \u cut short by the end of the string sets error_flag with the offset of the
// offending byte (one past it for a trailing backslash), and the rest of the
// string is dropped. A result transaction comes out for every decoded byte and
// for the last byte of every string; the one for the last byte carries done_res
// and the final decoded_length, and the block then starts afresh for the next
// string. Throughput is one byte per cycle while no waiting result is held by
// out_stall: the decode state (escape mode, hex digit count and three 16-bit
// counters) is updated by the logic between the input register and the result
// register. A byte accepted into the input register is decoded from there into
// the result register, where its result is offered. Each side holds one
// transaction, so the input register can take one more byte while a finished
// result waits for the consumer; beyond that the input stalls until the result is taken.
`include "json_string_unescape_defines.svh"

module json_string_unescape
  import jsu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        has_byte,
  output logic [7:0]  out_byte,
  output logic        done_res,
  output logic        error_flag,
  output logic [15:0] error_offset,
  output logic [15:0] decoded_length
);

  // Input register: one raw byte waiting for the decoder.
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_last;

  // Decode state, carried from byte to byte within a string.
  state_t  state;
  state_t  state_next;
  result_t res;

  logic advance;
  logic in_take;

  // Advance the held byte when the result register is free or is being emptied.
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  jsu_decode u_decode (
    .cur     (state),
    .in_byte (in_q_byte),
    .in_last (in_q_last),
    .nxt     (state_next),
    .res     (res)
  );

  // Input register: hold the byte until the decoder takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_byte <= in_byte;
      in_q_last <= in_last;
    end
  end

  // Decode state: step on every decoded byte, drop back to reset after the last one.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StateReset;
    end else if (advance) begin
      state <= in_q_last ? StateReset : state_next;
    end
  end

  // Result register: load when a byte yields a result, clear once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      has_byte       <= res.has_byte;
      out_byte       <= res.out_byte;
      done_res       <= res.done;
      error_flag     <= res.error_flag;
      error_offset   <= res.error_offset;
      decoded_length <= res.decoded_length;
    end
  end

  // A result with no decoded byte is only ever the end-of-string result.
  `JSU_ASSERT(a_result_has_cause, out_valid && !done_res |-> has_byte)
  // Fields that carry nothing read as zero.
  `JSU_ASSERT(a_byte_zero_when_empty, out_valid && !has_byte |-> out_byte == 8'd0)
  `JSU_ASSERT(a_offset_zero_without_error, out_valid && !error_flag |-> error_offset == 16'd0)
  // The last byte of a string leaves the decoder in its reset state.
  `JSU_ASSERT(a_restart_after_last, advance && in_q_last |=> state == StateReset)
  // Reset empties both registers.
  `JSU_ASSERT_ALWAYS(a_reset_empties, rst |=> !out_valid && !in_q_valid)

endmodule
